FILE: rtl/qfd_pkg.sv
// ----------------------------------------------------------------------------
// qfd_pkg
// Shared types, widths and constants of the 3x3x3 quadratic fit core.
// ----------------------------------------------------------------------------
`default_nettype none

package qfd_pkg;

  localparam int SampleBits = 24;
  localparam int NumBits    = 32;
  localparam int CoefBits   = SampleBits + 2;
  localparam int MulBits    = 33;
  localparam int ProdBits   = 2 * MulBits;
  localparam int AccBits    = 96;
  localparam int CofBits    = 56;
  localparam int LoBits     = 27;
  localparam int NumTerms   = 9;
  localparam int RecipShift = 35;
  localparam int LastDiv    = NumTerms - 1;
  localparam int LastUop    = 13;
  localparam int DataBytes  = (6 * SampleBits + 3 * CoefBits + 7) / 8;

  typedef logic signed [NumBits-1:0]  num_t;
  typedef num_t                       num_arr_t [NumTerms];
  typedef logic signed [CoefBits-1:0] coef_t;
  typedef logic signed [CofBits-1:0]  cof_t;

  typedef enum logic [3:0] {
    SRC_UU = 4'd0, SRC_VV = 4'd1, SRC_WW = 4'd2,
    SRC_UV = 4'd3, SRC_UW = 4'd4, SRC_VW = 4'd5,
    SRC_C1H = 4'd6, SRC_C1L = 4'd7,
    SRC_C2H = 4'd8, SRC_C2L = 4'd9,
    SRC_C3H = 4'd10, SRC_C3L = 4'd11
  } src_e;

  typedef enum logic [2:0] {
    SAVE_NONE = 3'd0, SAVE_D2 = 3'd1, SAVE_COF1 = 3'd2,
    SAVE_COF2 = 3'd3, SAVE_COF3 = 3'd4
  } save_e;

  typedef struct packed {
    src_e  a_sel;
    src_e  b_sel;
    logic  clr;
    logic  sub;
    logic  shift;
    save_e save;
  } uop_t;

  // minors program: d2, three cofactors, then d3 from split cofactors
  function automatic uop_t det_uop(input logic [3:0] step);
    uop_t u;
    u = '{SRC_UU, SRC_VV, 1'b1, 1'b0, 1'b0, SAVE_NONE};
    unique case (step)
      4'd0:  u = '{SRC_UU,  SRC_VV, 1'b1, 1'b0, 1'b0, SAVE_NONE};
      4'd1:  u = '{SRC_UV,  SRC_UV, 1'b0, 1'b1, 1'b0, SAVE_D2};
      4'd2:  u = '{SRC_VV,  SRC_WW, 1'b1, 1'b0, 1'b0, SAVE_NONE};
      4'd3:  u = '{SRC_VW,  SRC_VW, 1'b0, 1'b1, 1'b0, SAVE_COF1};
      4'd4:  u = '{SRC_VW,  SRC_UW, 1'b1, 1'b0, 1'b0, SAVE_NONE};
      4'd5:  u = '{SRC_UV,  SRC_WW, 1'b0, 1'b1, 1'b0, SAVE_COF2};
      4'd6:  u = '{SRC_UV,  SRC_VW, 1'b1, 1'b0, 1'b0, SAVE_NONE};
      4'd7:  u = '{SRC_VV,  SRC_UW, 1'b0, 1'b1, 1'b0, SAVE_COF3};
      4'd8:  u = '{SRC_C1H, SRC_UU, 1'b1, 1'b0, 1'b1, SAVE_NONE};
      4'd9:  u = '{SRC_C1L, SRC_UU, 1'b0, 1'b0, 1'b0, SAVE_NONE};
      4'd10: u = '{SRC_C2H, SRC_UV, 1'b0, 1'b0, 1'b1, SAVE_NONE};
      4'd11: u = '{SRC_C2L, SRC_UV, 1'b0, 1'b0, 1'b0, SAVE_NONE};
      4'd12: u = '{SRC_C3H, SRC_UW, 1'b0, 1'b0, 1'b1, SAVE_NONE};
      4'd13: u = '{SRC_C3L, SRC_UW, 1'b0, 1'b0, 1'b0, SAVE_NONE};
      default: u = '{SRC_UU, SRC_VV, 1'b1, 1'b0, 1'b0, SAVE_NONE};
    endcase
    return u;
  endfunction

  // divisor class of a term: 18 for first, 9 for second, 12 for cross
  function automatic logic [4:0] term_div(input logic [3:0] idx);
    logic [4:0] d;
    case (idx) inside
      [4'd0:4'd2]: d = 5'd18;
      [4'd3:4'd5]: d = 5'd9;
      default:     d = 5'd12;
    endcase
    return d;
  endfunction

  // ceil(2^35 / d)
  function automatic logic [31:0] term_recip(input logic [3:0] idx);
    logic [31:0] m;
    case (idx) inside
      [4'd0:4'd2]: m = 32'd1908874354;
      [4'd3:4'd5]: m = 32'd3817748708;
      default:     m = 32'd2863311531;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/quadratic_fit_derivatives_3x3x3_core.sv
// ----------------------------------------------------------------------------
// quadratic_fit_derivatives_3x3x3_core
// Quadratic facet fit over a 3x3x3 neighborhood with a Hessian maximum test.
// ----------------------------------------------------------------------------
// Samples load at one per cycle while in ST_LOAD (27 samples per neighborhood).
// After the last sample: rounding division of the nine terms (ST_DMUL, ST_DFIX
// per term on the shared multiplier), minor evaluation of 14 products (ST_MUL,
// ST_ACC per product); the result is registered in ST_OUT. Input is held off
// meanwhile. Reset clears position counters, sequencer and output valid.
`default_nettype none

module quadratic_fit_derivatives_3x3x3_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output      logic         s_axis_tready_o,
  input  wire logic [23:0]  s_axis_tdata_i,   // voxel_value[23:0]
  output      logic         m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // first_u, first_v, first_w (24 each), second_uu, second_vv, second_ww
  // (26 each), cross_uv, cross_uw, cross_vw (24 each), 2 zero pad bits
  output      logic [qfd_pkg::DataBytes*8-1:0] m_axis_tdata_o,
  output      logic         m_axis_tuser_o    // is_maximum
);

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_DMUL = 6'b000010,
    ST_DFIX = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_ACC  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] cnt_q;
  logic       in_acc, last;
  qfd_pkg::num_arr_t num;
  qfd_pkg::coef_t c_q [qfd_pkg::NumTerms];
  qfd_pkg::cof_t  cof_q [3];
  logic signed [qfd_pkg::AccBits-1:0] acc_q, acc_d, p_ext;
  logic d2neg_q;
  logic [31:0] a_q;
  logic        neg_q;
  logic signed [qfd_pkg::MulBits-1:0]  mul_a, mul_b;
  logic signed [qfd_pkg::ProdBits-1:0] prod;
  qfd_pkg::uop_t uop;
  logic out_valid_q, out_user_q;
  logic [qfd_pkg::DataBytes*8-1:0] out_data_q;
  logic out_free, maxok;
  qfd_pkg::num_t cur_num;
  logic [31:0] cur_mag, cur_a;
  logic [4:0]  cur_d;
  logic [28:0] q0, q1;
  logic signed [33:0] rem;
  logic signed [29:0] qs;
  qfd_pkg::coef_t sat_val;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_LOAD);

  qfd_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_acc),
    .sample_i (s_axis_tdata_i),
    .last_o   (last),
    .num_o    (num)
  );

  function automatic logic signed [qfd_pkg::MulBits-1:0] src_val(
      input qfd_pkg::src_e sel, input qfd_pkg::coef_t cu, input qfd_pkg::coef_t cv,
      input qfd_pkg::coef_t cw, input qfd_pkg::coef_t xuv, input qfd_pkg::coef_t xuw,
      input qfd_pkg::coef_t xvw, input qfd_pkg::cof_t f1, input qfd_pkg::cof_t f2,
      input qfd_pkg::cof_t f3);
    logic signed [qfd_pkg::MulBits-1:0] r;
    unique case (sel)
      qfd_pkg::SRC_UU:  r = qfd_pkg::MulBits'(cu);
      qfd_pkg::SRC_VV:  r = qfd_pkg::MulBits'(cv);
      qfd_pkg::SRC_WW:  r = qfd_pkg::MulBits'(cw);
      qfd_pkg::SRC_UV:  r = qfd_pkg::MulBits'(xuv);
      qfd_pkg::SRC_UW:  r = qfd_pkg::MulBits'(xuw);
      qfd_pkg::SRC_VW:  r = qfd_pkg::MulBits'(xvw);
      qfd_pkg::SRC_C1H: r = qfd_pkg::MulBits'(f1 >>> qfd_pkg::LoBits);
      qfd_pkg::SRC_C1L: r = {6'b0, f1[qfd_pkg::LoBits-1:0]};
      qfd_pkg::SRC_C2H: r = qfd_pkg::MulBits'(f2 >>> qfd_pkg::LoBits);
      qfd_pkg::SRC_C2L: r = {6'b0, f2[qfd_pkg::LoBits-1:0]};
      qfd_pkg::SRC_C3H: r = qfd_pkg::MulBits'(f3 >>> qfd_pkg::LoBits);
      qfd_pkg::SRC_C3L: r = {6'b0, f3[qfd_pkg::LoBits-1:0]};
      default:          r = '0;
    endcase
    return r;
  endfunction

  assign uop     = qfd_pkg::det_uop(cnt_q);
  assign cur_num = num[cnt_q];
  assign cur_d   = qfd_pkg::term_div(cnt_q);
  assign cur_mag = cur_num[31] ? 32'(-cur_num) : 32'(cur_num);
  assign cur_a   = cur_mag + 32'(cur_d >> 1);

  always_comb begin
    if (state_q == ST_DMUL) begin
      mul_a = {1'b0, cur_a};
      mul_b = {1'b0, qfd_pkg::term_recip(cnt_q)};
    end else begin
      mul_a = src_val(uop.a_sel, c_q[3], c_q[4], c_q[5], c_q[6], c_q[7], c_q[8],
                      cof_q[0], cof_q[1], cof_q[2]);
      mul_b = src_val(uop.b_sel, c_q[3], c_q[4], c_q[5], c_q[6], c_q[7], c_q[8],
                      cof_q[0], cof_q[1], cof_q[2]);
    end
  end

  qfd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // reciprocal estimate is exact or one high
  always_comb begin
    logic [33:0] qd;
    q0  = prod[63:qfd_pkg::RecipShift];
    qd  = 34'(q0) * 34'(qfd_pkg::term_div(cnt_q));
    rem = $signed({2'b00, a_q}) - $signed(qd);
    q1  = rem[33] ? q0 - 29'd1 : q0;
    qs  = neg_q ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
    if (cnt_q >= 4'd3 && cnt_q <= 4'd5) begin
      if (qs > 30'sd33554431)       sat_val = 26'sd33554431;
      else if (qs < -30'sd33554432) sat_val = -26'sd33554432;
      else                          sat_val = qfd_pkg::CoefBits'(qs);
    end else begin
      if (qs > 30'sd8388607)        sat_val = 26'sd8388607;
      else if (qs < -30'sd8388608)  sat_val = -26'sd8388608;
      else                          sat_val = qfd_pkg::CoefBits'(qs);
    end
  end

  always_comb begin
    p_ext = qfd_pkg::AccBits'(prod);
    if (uop.shift) p_ext = p_ext <<< qfd_pkg::LoBits;
    acc_d = (uop.clr ? '0 : acc_q) + (uop.sub ? -p_ext : p_ext);
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign maxok = (c_q[3][qfd_pkg::CoefBits-1] || c_q[3] == '0) && !d2neg_q &&
                 (acc_q[qfd_pkg::AccBits-1] || acc_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_acc && last) state_d = ST_DMUL;
      ST_DMUL: state_d = ST_DFIX;
      ST_DFIX: state_d = (cnt_q == 4'(qfd_pkg::LastDiv)) ? ST_MUL : ST_DMUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = (cnt_q == 4'(qfd_pkg::LastUop)) ? ST_OUT : ST_MUL;
      ST_OUT:  if (out_free) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DFIX && cnt_q == 4'(qfd_pkg::LastDiv)) ||
          (state_q == ST_LOAD)) begin
        cnt_q <= '0;
      end else if (state_q == ST_DFIX || state_q == ST_ACC) begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DMUL) begin
      a_q   <= cur_a;
      neg_q <= cur_num[31];
    end
    if (state_q == ST_DFIX) begin
      c_q[cnt_q] <= sat_val;
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_d;
      unique case (uop.save)
        qfd_pkg::SAVE_D2:   d2neg_q  <= acc_d[qfd_pkg::AccBits-1];
        qfd_pkg::SAVE_COF1: cof_q[0] <= acc_d[qfd_pkg::CofBits-1:0];
        qfd_pkg::SAVE_COF2: cof_q[1] <= acc_d[qfd_pkg::CofBits-1:0];
        qfd_pkg::SAVE_COF3: cof_q[2] <= acc_d[qfd_pkg::CofBits-1:0];
        default: ;
      endcase
    end
    if (state_q == ST_OUT && out_free) begin
      out_user_q <= maxok;
      if (maxok) begin
        out_data_q <= {2'b00, c_q[8][23:0], c_q[7][23:0], c_q[6][23:0],
                       c_q[5], c_q[4], c_q[3],
                       c_q[2][23:0], c_q[1][23:0], c_q[0][23:0]};
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTHESIS
  a_hold_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last) |=> !s_axis_tready_o)
    else $error("input taken after last sample");
  a_zero_when_not_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("coefficients not cleared");
  a_uop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_ACC) |-> (cnt_q <= 4'(qfd_pkg::LastUop)))
    else $error("minor program overrun");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

FILE: rtl/qfd_accum.sv
// ----------------------------------------------------------------------------
// qfd_accum
// Raster position counters and the nine weighted numerator accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module qfd_accum (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 en_i,
  input  wire logic signed [qfd_pkg::SampleBits-1:0] sample_i,
  output      logic                                 last_o,
  output      qfd_pkg::num_arr_t                    num_o
);

  logic [1:0] u_q, v_q, w_q;
  qfd_pkg::num_arr_t num_q;
  logic first;

  // weight -1/0/+1 for first differences
  function automatic logic signed [2:0] s_of(input logic [1:0] k);
    logic signed [2:0] r;
    case (k)
      2'd0:    r = -3'sd1;
      2'd2:    r = 3'sd1;
      default: r = 3'sd0;
    endcase
    return r;
  endfunction

  // weight +1/-2/+1 for second differences
  function automatic logic signed [2:0] t_of(input logic [1:0] k);
    logic signed [2:0] r;
    case (k)
      2'd1:    r = -3'sd2;
      default: r = 3'sd1;
    endcase
    return r;
  endfunction

  function automatic qfd_pkg::num_t weigh(input qfd_pkg::num_t x,
                                          input logic signed [2:0] wt);
    qfd_pkg::num_t r;
    case (wt)
      3'sd1:   r = x;
      -3'sd1:  r = -x;
      -3'sd2:  r = -(x <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [2:0] s_pair(input logic [1:0] a, input logic [1:0] b);
    logic signed [2:0] r;
    if (a == 2'd1 || b == 2'd1) begin
      r = 3'sd0;
    end else if (a == b) begin
      r = 3'sd1;
    end else begin
      r = -3'sd1;
    end
    return r;
  endfunction

  assign first  = (u_q == 2'd0) && (v_q == 2'd0) && (w_q == 2'd0);
  assign last_o = (u_q == 2'd2) && (v_q == 2'd2) && (w_q == 2'd2);
  assign num_o  = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_q <= '0;
      v_q <= '0;
      w_q <= '0;
    end else if (en_i) begin
      if (w_q == 2'd2) begin
        w_q <= '0;
        if (v_q == 2'd2) begin
          v_q <= '0;
          u_q <= (u_q == 2'd2) ? 2'd0 : u_q + 2'd1;
        end else begin
          v_q <= v_q + 2'd1;
        end
      end else begin
        w_q <= w_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qfd_pkg::num_t x;
    logic signed [2:0] wt [qfd_pkg::NumTerms];
    x = qfd_pkg::NumBits'(sample_i);
    wt[0] = s_of(u_q);
    wt[1] = s_of(v_q);
    wt[2] = s_of(w_q);
    wt[3] = t_of(u_q);
    wt[4] = t_of(v_q);
    wt[5] = t_of(w_q);
    wt[6] = s_pair(u_q, v_q);
    wt[7] = s_pair(u_q, w_q);
    wt[8] = s_pair(v_q, w_q);
    if (en_i) begin
      for (int i = 0; i < qfd_pkg::NumTerms; i++) begin
        num_q[i] <= (first ? qfd_pkg::num_t'(0) : num_q[i]) + weigh(x, wt[i]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qfd_mul.sv
// ----------------------------------------------------------------------------
// qfd_mul
// Shared signed 33x33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module qfd_mul (
  input  wire logic                                  clk_i,
  input  wire logic signed [qfd_pkg::MulBits-1:0]    a_i,
  input  wire logic signed [qfd_pkg::MulBits-1:0]    b_i,
  output      logic signed [qfd_pkg::ProdBits-1:0]   prod_o
);

  logic signed [qfd_pkg::ProdBits-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= qfd_pkg::ProdBits'(a_i) * qfd_pkg::ProdBits'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire
